// ----- hw/rtl/mm3h_pkg.sv -----
// Shared constants, types and codes for the MurmurHash3 x86_32 stream hash core.
`timescale 1ns / 1ps

package mm3h_pkg;

   // Hash constants
   localparam logic [31:0] SEED_RESET = 32'd16769023;
   localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2     = 32'h1b873593;
   localparam logic [31:0] MIX_ADD    = 32'he6546b64;
   localparam logic [31:0] FMIX_C1    = 32'h85ebca6b;
   localparam logic [31:0] FMIX_C2    = 32'hc2b2ae35;

   // Byte count of a word that carries all four bytes
   localparam logic [2:0]  FULL_COUNT = 3'd4;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_WORD,
      ST_MUL_ROT,
      ST_ACC,
      ST_FIN1,
      ST_FIN2,
      ST_EMIT
   } mm3h_state_type;

   // Multiplier operand selection
   typedef enum logic [2:0] {
      OP_NONE,
      OP_MUL_WORD,
      OP_MUL_ROT,
      OP_MUL_FIN1,
      OP_MUL_FIN2
   } mm3h_op_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        load;
      mm3h_op_type op;
      logic        acc;
      logic        emit;
   } mm3h_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic in_empty;
      logic last;
      logic rsp_busy;
   } mm3h_stat_type;

endpackage

// ----- hw/rtl/mm3h_ctrl.sv -----
// Sequencer for the hash core: walks each word through multiply, accumulate and finalize.
`timescale 1ns / 1ps

module mm3h_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mm3h_pkg::mm3h_stat_type stat,
   output mm3h_pkg::mm3h_cmd_type  cmd
);

   mm3h_pkg::mm3h_state_type state_ff;
   mm3h_pkg::mm3h_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm3h_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd.load  = 1'b0;
      cmd.op    = mm3h_pkg::OP_NONE;
      cmd.acc   = 1'b0;
      cmd.emit  = 1'b0;
      case (state_ff)
         mm3h_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               // an empty last word skips the mix entirely
               state_in = stat.in_empty ? mm3h_pkg::ST_FIN1 : mm3h_pkg::ST_MUL_WORD;
            end
         end
         mm3h_pkg::ST_MUL_WORD: begin
            cmd.op   = mm3h_pkg::OP_MUL_WORD;
            state_in = mm3h_pkg::ST_MUL_ROT;
         end
         mm3h_pkg::ST_MUL_ROT: begin
            cmd.op   = mm3h_pkg::OP_MUL_ROT;
            state_in = mm3h_pkg::ST_ACC;
         end
         mm3h_pkg::ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = stat.last ? mm3h_pkg::ST_FIN1 : mm3h_pkg::ST_IDLE;
         end
         mm3h_pkg::ST_FIN1: begin
            cmd.op   = mm3h_pkg::OP_MUL_FIN1;
            state_in = mm3h_pkg::ST_FIN2;
         end
         mm3h_pkg::ST_FIN2: begin
            cmd.op   = mm3h_pkg::OP_MUL_FIN2;
            state_in = mm3h_pkg::ST_EMIT;
         end
         mm3h_pkg::ST_EMIT: begin
            // hold until the output register is free
            if (!stat.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = mm3h_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mm3h_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/mm3h_dpath.sv -----
// Datapath of the hash core: seed, running hash, length, shared multiplier, output register.
`timescale 1ns / 1ps

module mm3h_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [31:0]            csr_seed,
   input  logic [31:0]            req_data_word,
   input  logic [2:0]             req_byte_count,
   input  logic                   req_last_item,
   input  logic                   rsp_stall,
   input  mm3h_pkg::mm3h_cmd_type  cmd,
   output mm3h_pkg::mm3h_stat_type stat,
   output logic                   rsp_valid,
   output logic [31:0]            rsp_hash_value
);

   logic [31:0] seed_ff;
   logic [31:0] hash_ff;
   logic [31:0] hash_in;
   logic [31:0] len_ff;
   logic [31:0] word_ff;
   logic        full_ff;
   logic        last_ff;
   logic [31:0] prod_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_hash_ff;

   logic [2:0]  count;
   logic [31:0] mask;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [31:0] mul_p;
   logic [31:0] fin_x;
   logic [31:0] acc_x;
   logic [31:0] acc_r;

   // Effective byte count: saturate, and a word that is not last is full
   assign count = (!req_last_item || (req_byte_count inside {[3'd5:3'd7]}))
                  ? mm3h_pkg::FULL_COUNT : req_byte_count;

   // Keep only the valid low bytes
   always_comb begin
      case (count)
         3'd1:    mask = 32'h0000_00ff;
         3'd2:    mask = 32'h0000_ffff;
         3'd3:    mask = 32'h00ff_ffff;
         3'd4:    mask = 32'hffff_ffff;
         default: mask = 32'h0000_0000;
      endcase
   end

   // Shared multiplier operand select, low 32 bits of the product kept
   assign fin_x = hash_ff ^ len_ff;
   always_comb begin
      case (cmd.op)
         mm3h_pkg::OP_MUL_WORD: begin
            mul_a = word_ff;
            mul_b = mm3h_pkg::MIX_C1;
         end
         mm3h_pkg::OP_MUL_ROT: begin
            mul_a = {prod_ff[16:0], prod_ff[31:17]};
            mul_b = mm3h_pkg::MIX_C2;
         end
         mm3h_pkg::OP_MUL_FIN1: begin
            mul_a = fin_x ^ {16'd0, fin_x[31:16]};
            mul_b = mm3h_pkg::FMIX_C1;
         end
         mm3h_pkg::OP_MUL_FIN2: begin
            mul_a = prod_ff ^ {13'd0, prod_ff[31:13]};
            mul_b = mm3h_pkg::FMIX_C2;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Block mix accumulate: xor, rotate 13, times five plus constant; a tail word is only xored, emit reloads the seed
   assign acc_x = hash_ff ^ prod_ff;
   assign acc_r = {acc_x[18:0], acc_x[31:19]};
   always_comb begin
      hash_in = hash_ff;
      if (cmd.acc) begin
         hash_in = full_ff ? ({acc_r[29:0], 2'b00} + acc_r + mm3h_pkg::MIX_ADD) : acc_x;
      end else if (cmd.emit) begin
         hash_in = seed_ff;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= mm3h_pkg::SEED_RESET;
         hash_ff      <= mm3h_pkg::SEED_RESET;
         len_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            seed_ff <= csr_seed;
         end
         hash_ff <= hash_in;
         if (cmd.emit) begin
            len_ff <= 32'd0;
         end else if (cmd.load) begin
            len_ff <= len_ff + {29'd0, count};
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= req_data_word & mask;
         full_ff <= (count == mm3h_pkg::FULL_COUNT);
         last_ff <= req_last_item;
      end
      if (cmd.op != mm3h_pkg::OP_NONE) begin
         prod_ff <= mul_p;
      end
      if (cmd.emit) begin
         rsp_hash_ff <= prod_ff ^ {16'd0, prod_ff[31:16]};
      end
   end

   // Status to the controller
   assign stat.in_empty = (count == 3'd0);
   assign stat.last     = last_ff;
   assign stat.rsp_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

// ----- hw/rtl/murmur3_32_stream_hash_core.sv -----
// Top level of the MurmurHash3 x86_32 stream hash core.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | data_word, byte_count, last_item
//  rsp     | out       | rsp_valid/rsp_stall  | hash_value
//  csr     | in        | csr_valid/csr_ready  | seed
//
// A word that is not last passes capture, MUL_WORD, MUL_ROT and accumulate; a last
// word with bytes adds finalize states FIN1, FIN2, EMIT; an empty one skips to FIN1.
// All multiplies share one 32x32 multiplier, one per cycle.
// The final cycle waits while the output register holds a result not yet taken.
// Reset loads the seed register and running hash with 16769023 and clears the length.
`timescale 1ns / 1ps

module murmur3_32_stream_hash_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_seed,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);

   mm3h_pkg::mm3h_cmd_type  cmd;
   mm3h_pkg::mm3h_stat_type stat;

   // Seed register takes every transfer
   assign csr_ready = 1'b1;

   mm3h_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   mm3h_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_seed       (csr_seed),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last_item  (req_last_item),
      .rsp_stall      (rsp_stall),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

// ----- hw/rtl/mm3h_checker.sv -----
// Port-level checks for the hash core, bound to the top level.
`timescale 1ns / 1ps

module mm3h_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_hash_value
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hash_value))
      else $error("stalled result changed");

   // No result right out of reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // One word at a time: an accepted transfer blocks the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken on back-to-back cycles");

   // A result appears only after the finalize cycles, while input is blocked
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall) && $past(req_stall, 2))
      else $error("result appeared without finalize cycles");

endmodule

bind murmur3_32_stream_hash_core mm3h_checker u_mm3h_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hash_value (rsp_hash_value)
);

// ----- sim/mm3h_hash_checker.sv -----
// Checker that predicts the stream hash core's results and compares them on the rsp channel.
`timescale 1ns / 1ps

module mm3h_hash_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_seed,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_item,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_hash_value,
   output int          fail_count,
   output int          hashes_pending
);

   localparam int REPORT_LIMIT = 10;

   // Shadow copy of the core's seed register and message state
   logic [31:0] seed_shadow;
   logic [31:0] hash_acc;
   logic [31:0] len_acc;
   logic [31:0] expected_hashes [$];

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   // Block scramble: multiply, rotate 15, multiply
   function automatic logic [31:0] scramble_word(input logic [31:0] k);
      logic [31:0] t;
      t = k * mm3h_pkg::MIX_C1;
      t = rotl32(t, 15);
      return t * mm3h_pkg::MIX_C2;
   endfunction

   // Standard fmix32 avalanche
   function automatic logic [31:0] fmix32(input logic [31:0] h);
      logic [31:0] t;
      t = h ^ (h >> 16);
      t = t * mm3h_pkg::FMIX_C1;
      t = t ^ (t >> 13);
      t = t * mm3h_pkg::FMIX_C2;
      return t ^ (t >> 16);
   endfunction

   task automatic log_failure(input string msg);
      fail_count = fail_count + 1;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%s", msg);
      end
   endtask

   always @(posedge clock) begin : track
      logic [2:0]  take;
      logic [31:0] mask;
      logic [31:0] want;
      if (reset) begin
         seed_shadow    = mm3h_pkg::SEED_RESET;
         hash_acc       = mm3h_pkg::SEED_RESET;
         len_acc        = '0;
         fail_count     = 0;
         hashes_pending = 0;
         expected_hashes.delete();
      end else begin
         // Result transfer: compare with the oldest predicted hash
         if (rsp_valid && !rsp_stall) begin
            if (expected_hashes.size() == 0) begin
               log_failure($sformatf("unexpected hash %08h at %0t", rsp_hash_value, $realtime));
            end else begin
               want = expected_hashes.pop_front();
               if (rsp_hash_value !== want) begin
                  log_failure($sformatf("hash mismatch at %0t: expected %08h, got %08h",
                                        $realtime, want, rsp_hash_value));
               end
            end
         end

         // Word transfer: absorb into the running hash
         if (req_valid && !req_stall) begin
            take = req_byte_count;
            // non-last words always count as full; counts above four saturate
            if (take > mm3h_pkg::FULL_COUNT || !req_last_item) take = mm3h_pkg::FULL_COUNT;
            if (take == mm3h_pkg::FULL_COUNT) begin
               hash_acc = rotl32(hash_acc ^ scramble_word(req_data_word), 13);
               hash_acc = hash_acc * 32'd5 + mm3h_pkg::MIX_ADD;
            end else if (take != 3'd0) begin
               // tail: bytes above the count are dropped
               mask     = (32'h1 << {take, 3'b000}) - 32'h1;
               hash_acc = hash_acc ^ scramble_word(req_data_word & mask);
            end
            len_acc = len_acc + {29'd0, take};
            if (req_last_item) begin
               expected_hashes.push_back(fmix32(hash_acc ^ len_acc));
               hash_acc = seed_shadow;
               len_acc  = '0;
            end
         end

         // Seed write only takes effect at the next reload
         if (csr_valid && csr_ready) seed_shadow = csr_seed;

         hashes_pending = expected_hashes.size();
      end
   end

endmodule

// ----- sim/tb_murmur3_32_stream_hash_core.sv -----
// Testbench top for the MurmurHash3 stream hash core: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_murmur3_32_stream_hash_core;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASES        = 8;
   localparam int PHASE_WORDS   = 150;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_seed;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_data_word;
   logic [2:0]  req_byte_count;
   logic        req_last_item;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_hash_value;

   int   fail_count;
   int   hashes_pending;
   int   quiet_cycles = 0;
   logic no_gaps;

   murmur3_32_stream_hash_core DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_seed       (csr_seed),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last_item  (req_last_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

   mm3h_hash_checker u_hash_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_seed       (csr_seed),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last_item  (req_last_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value),
      .fail_count     (fail_count),
      .hashes_pending (hashes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: too many cycles without any transfer ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver back-pressure: free stretches, short stalls, a few long ones
   initial begin : rsp_pressure
      int r;
      int hold;
      rsp_stall = 1'b0;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 25) hold = 0;
         else if (r < 90) hold = $urandom_range(1, 3);
         else hold = $urandom_range(10, 60);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
         hold = (r < 25) ? $urandom_range(20, 80) : $urandom_range(1, 6);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [31:0] random_word();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 32'h0000_0000;
      if (r == 1) return 32'hffff_ffff;
      return $urandom;
   endfunction

   // One word transfer on req, then an optional gap
   task automatic send_word(input logic [31:0] word, input logic [2:0] count,
                            input logic last);
      int gap;
      @(negedge clock);
      req_data_word  = word;
      req_byte_count = count;
      req_last_item  = last;
      req_valid      = 1'b1;
      do @(posedge clock); while (req_stall);
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_seed(input logic [31:0] value);
      @(negedge clock);
      csr_seed  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Drain all pending hashes and let the core fall idle
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (hashes_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly well-formed messages; some with odd counts on body words or the last word
   task automatic send_random_message(output int words);
      int         kind;
      int         body;
      logic [2:0] cnt;
      kind = $urandom_range(0, 99);
      body = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 6);
      for (int i = 0; i < body; i++) begin
         cnt = (kind < 85) ? mm3h_pkg::FULL_COUNT : 3'($urandom_range(0, 7));
         send_word(random_word(), cnt, 1'b0);
      end
      if (kind >= 95) cnt = 3'($urandom_range(5, 7));
      else cnt = 3'($urandom_range(0, 4));
      send_word(random_word(), cnt, 1'b1);
      words = body + 1;
   endtask

   initial begin : stimulus
      int sent;
      int n;
      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_seed       = '0;
      req_valid      = 1'b0;
      req_data_word  = '0;
      req_byte_count = '0;
      req_last_item  = 1'b0;
      no_gaps        = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Reset seed: empty message, every tail length, saturated counts
      send_word(32'hffff_ffff, 3'd0, 1'b1);
      send_word(32'hffff_ffff, 3'd1, 1'b1);
      send_word(32'ha5a5_a5a5, 3'd2, 1'b1);
      send_word(32'hffff_ffff, 3'd3, 1'b1);
      send_word(32'h0000_0000, mm3h_pkg::FULL_COUNT, 1'b1);
      send_word(32'h1234_5678, 3'd5, 1'b1);
      send_word(32'h8765_4321, 3'd6, 1'b1);
      send_word(32'hffff_ffff, 3'd7, 1'b1);

      // Short and oversized counts on body words are taken as full
      send_word(32'hffff_ffff, 3'd0, 1'b0);
      send_word(32'h0f0f_0f0f, 3'd1, 1'b0);
      send_word(32'hf0f0_f0f0, 3'd7, 1'b0);
      send_word(32'hffff_ffff, mm3h_pkg::FULL_COUNT, 1'b1);

      send_word(32'h0000_0000, mm3h_pkg::FULL_COUNT, 1'b0);
      send_word(32'hffff_ffff, mm3h_pkg::FULL_COUNT, 1'b0);
      send_word(32'hdead_beef, 3'd3, 1'b1);

      // Seed extremes; a new seed shows up after the reload at the next message end
      settle();
      write_seed(32'h0000_0000);
      send_word(32'h0000_0000, mm3h_pkg::FULL_COUNT, 1'b1);
      send_word(32'h0000_0000, 3'd0, 1'b1);
      settle();
      write_seed(32'hffff_ffff);
      send_word(32'hffff_ffff, 3'd2, 1'b1);
      send_word(32'hffff_ffff, mm3h_pkg::FULL_COUNT, 1'b1);

      // Random phases, each after a seed write cycling through zero, all ones, random and the reset seed
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         case (ph % 4)
            0: begin
               write_seed(32'h0000_0000);
            end
            1: begin
               write_seed(32'hffff_ffff);
            end
            2: begin
               write_seed($urandom);
            end
            default: begin
               write_seed(mm3h_pkg::SEED_RESET);
            end
         endcase
         no_gaps = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            send_random_message(n);
            sent = sent + n;
         end
      end

      no_gaps = 1'b0;
      settle();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
